>>> rtl/xor_score_argmax_search_top_defines.svh
// assertion macros shared by the rtl
`ifndef XOR_SCORE_ARGMAX_SEARCH_TOP_DEFINES_SVH
`define XOR_SCORE_ARGMAX_SEARCH_TOP_DEFINES_SVH

// same-cycle implication
`define XSAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XSAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/xsas_pkg.sv
package xsas_pkg;

	localparam int QUERY_DEPTH = 1024;
	localparam int POS_W       = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
	localparam int SIZE_W      = 11;
	localparam int ADDR_W      = 10;
	localparam int BYTE_W      = 8;
	localparam int SCORE_W     = 64;
	localparam int INDEX_W     = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1);
	localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

	localparam logic MODE_QUERY   = 1'b0;
	localparam logic MODE_PROFILE = 1'b1;

endpackage

>>> rtl/xsas_ram.sv
module xsas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/xor_score_argmax_search_top.sv
// channel | direction | handshake                 | payload
// cfg     | in        | cfg_valid / cfg_ready     | cfg_data (vector_size)
// in      | in        | in_valid / in_ready       | mode, query_address, data_byte, last
// out     | out       | out_valid / out_ready     | best_index, best_score
//
// one item per cycle; a query write lands in the query ram at acceptance
// a profile byte reads the ram at acceptance and is scored from stage 1 (xor, add, compare) when stage 1 fires
// the result of a last byte enters the output register at the edge at which it is scored
// in_ready drops only while a last byte waits behind an unaccepted result
// arst_n clears the run state and vector_size (to 1); the query ram is not cleared
`include "xor_score_argmax_search_top_defines.svh"

module xor_score_argmax_search_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [xsas_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                mode,
	input  logic [xsas_pkg::ADDR_W-1:0]         query_address,
	input  logic [xsas_pkg::BYTE_W-1:0]         data_byte,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [xsas_pkg::INDEX_W-1:0]        best_index,
	output logic signed [xsas_pkg::SCORE_W-1:0] best_score
);

	logic [xsas_pkg::SIZE_W-1:0]  vector_size_q;
	logic [xsas_pkg::SIZE_W-1:0]  size_eff;
	logic [xsas_pkg::POS_W-1:0]   pos_q;
	logic [xsas_pkg::POS_W:0]     pos_inc;
	logic                         complete;
	logic                         wrap;
	logic                         in_fire;
	logic                         prof_fire;
	logic                         query_we;

	logic                         s1_valid_q;
	logic                         last_s1;
	logic                         complete_s1;
	logic [xsas_pkg::BYTE_W-1:0]  data_s1;
	logic [xsas_pkg::BYTE_W-1:0]  q_byte;

	logic [xsas_pkg::SCORE_W-1:0] running_sum_q;
	logic [xsas_pkg::SCORE_W-1:0] top_score_q;
	logic [xsas_pkg::INDEX_W-1:0] top_index_q;
	logic [xsas_pkg::INDEX_W-1:0] vectors_done_q;
	logic [xsas_pkg::SCORE_W-1:0] term;
	logic [xsas_pkg::SCORE_W-1:0] sum_nxt;
	logic [xsas_pkg::SCORE_W-1:0] top_score_nxt;
	logic [xsas_pkg::INDEX_W-1:0] top_index_nxt;
	logic                         s1_fire;
	logic                         s1_stall;

	logic                         out_valid_q;
	logic [xsas_pkg::INDEX_W-1:0] best_index_q;
	logic [xsas_pkg::SCORE_W-1:0] best_score_q;

	// config: always ready; the user must write it only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_size_q <= xsas_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vector_size_q <= cfg_data;
		end
	end

	always_comb begin
		if (32'(vector_size_q) > xsas_pkg::QUERY_DEPTH) begin
			size_eff = xsas_pkg::SIZE_W'(xsas_pkg::QUERY_DEPTH);
		end else begin
			size_eff = vector_size_q;
		end
	end

	// a last byte stalls only when the output register is full and not draining
	assign s1_stall = s1_valid_q && last_s1 && out_valid_q && !out_ready;
	assign s1_fire  = s1_valid_q && !s1_stall;
	assign in_ready = !s1_stall;

	assign in_fire   = in_valid && in_ready;
	assign prof_fire = in_fire && (mode == xsas_pkg::MODE_PROFILE);
	assign query_we  = in_fire && (mode == xsas_pkg::MODE_QUERY) &&
		(32'(query_address) < xsas_pkg::QUERY_DEPTH);

	// byte position advances at acceptance so the ram read lines up with stage 1
	assign pos_inc  = {1'b0, pos_q} + (xsas_pkg::POS_W+1)'(1);
	assign complete = (size_eff != '0) && (32'(pos_inc) == 32'(size_eff));
	assign wrap     = 32'(pos_inc) >= xsas_pkg::QUERY_DEPTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (prof_fire) begin
			if (last || complete || wrap) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_inc[xsas_pkg::POS_W-1:0];
			end
		end
	end

	xsas_ram #(
		.WIDTH(xsas_pkg::BYTE_W),
		.DEPTH(xsas_pkg::QUERY_DEPTH)
	) u_query_ram (
		.clk  (clk),
		.we   (query_we),
		.waddr(xsas_pkg::POS_W'(query_address)),
		.wdata(data_byte),
		.re   (prof_fire),
		.raddr(pos_q),
		.rdata(q_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= prof_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (prof_fire) begin
			last_s1     <= last;
			complete_s1 <= complete;
			data_s1     <= data_byte;
		end
	end

	// query byte is signed: term = sign-extended {q[7], data ^ q}
	always_comb begin
		term    = {{(xsas_pkg::SCORE_W-xsas_pkg::BYTE_W){q_byte[xsas_pkg::BYTE_W-1]}},
			data_s1 ^ q_byte};
		sum_nxt = running_sum_q + term;
		top_score_nxt = top_score_q;
		top_index_nxt = top_index_q;
		if (complete_s1 && ($signed(sum_nxt) > $signed(top_score_q))) begin
			top_score_nxt = sum_nxt;
			top_index_nxt = vectors_done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q  <= '0;
			top_score_q    <= xsas_pkg::SCORE_MIN;
			top_index_q    <= '0;
			vectors_done_q <= '0;
		end else if (s1_fire) begin
			if (last_s1) begin
				running_sum_q  <= '0;
				top_score_q    <= xsas_pkg::SCORE_MIN;
				top_index_q    <= '0;
				vectors_done_q <= '0;
			end else begin
				running_sum_q <= complete_s1 ? '0 : sum_nxt;
				top_score_q   <= top_score_nxt;
				top_index_q   <= top_index_nxt;
				if (complete_s1) begin
					vectors_done_q <= vectors_done_q + xsas_pkg::INDEX_W'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			best_index_q <= top_index_nxt;
			best_score_q <= top_score_nxt;
		end
	end

	assign out_valid  = out_valid_q;
	assign best_index = best_index_q;
	assign best_score = $signed(best_score_q);

	`XSAS_ASSERT_NEXT(a_profile_enters_s1, clk, arst_n,
		prof_fire, s1_valid_q, "accepted profile byte missing from stage 1")
	`XSAS_ASSERT_NEXT(a_last_gives_result, clk, arst_n,
		s1_fire && last_s1, out_valid, "last byte scored without a result")
	`XSAS_ASSERT_NEXT(a_last_clears_run, clk, arst_n,
		s1_fire && last_s1,
		(vectors_done_q == '0) && (running_sum_q == '0) &&
			(top_score_q == xsas_pkg::SCORE_MIN),
		"run state not cleared after last byte")
	`XSAS_ASSERT_NOW(a_held_result_blocks, clk, arst_n,
		out_valid && !out_ready && s1_valid_q && last_s1, !s1_fire,
		"last byte scored over an unaccepted result")

endmodule

>>> dv/best_match_checker.sv
module best_match_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [xsas_pkg::SIZE_W-1:0]         cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                mode,
	input  logic [xsas_pkg::ADDR_W-1:0]         query_address,
	input  logic [xsas_pkg::BYTE_W-1:0]         data_byte,
	input  logic                                last,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [xsas_pkg::INDEX_W-1:0]        best_index,
	input  logic signed [xsas_pkg::SCORE_W-1:0] best_score,
	output int                                  outstanding,
	output int                                  failures,
	output int                                  results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [xsas_pkg::INDEX_W-1:0]        idx;
		logic signed [xsas_pkg::SCORE_W-1:0] score;
	} best_t;

	best_t expected_best [$];

	// shadow of the query ram and of the search state
	logic [xsas_pkg::BYTE_W-1:0]         query_copy [xsas_pkg::QUERY_DEPTH];
	logic [xsas_pkg::SIZE_W-1:0]         size_reg;
	int unsigned                         pos;
	logic [xsas_pkg::SCORE_W-1:0]        sum;
	logic signed [xsas_pkg::SCORE_W-1:0] top_score;
	logic [xsas_pkg::INDEX_W-1:0]        top_idx;
	logic [xsas_pkg::INDEX_W-1:0]        done_count;
	int                                  fail_count = 0;
	int                                  seen_count = 0;

	task automatic clear_run();
		pos = 0;
		sum = '0;
		top_score = xsas_pkg::SCORE_MIN;
		top_idx = '0;
		done_count = '0;
	endtask

	task automatic note_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%s", msg);
	endtask

	task automatic score_byte(input logic [xsas_pkg::BYTE_W-1:0] b, input logic lst);
		int unsigned                  span;
		logic [xsas_pkg::BYTE_W-1:0]  q;
		logic [xsas_pkg::SCORE_W-1:0] term;
		best_t                        e;
		span = (size_reg > xsas_pkg::QUERY_DEPTH) ? xsas_pkg::QUERY_DEPTH : size_reg;
		q = query_copy[pos];
		// the query byte is signed, so its sign fills the upper bits of the term
		term = {{(xsas_pkg::SCORE_W-xsas_pkg::BYTE_W){q[xsas_pkg::BYTE_W-1]}}, b ^ q};
		sum = sum + term;
		pos++;
		if (span != 0 && pos == span) begin
			if ($signed(sum) > top_score) begin
				top_score = sum;
				top_idx = done_count;
			end
			sum = '0;
			pos = 0;
			done_count++;
		end else if (pos >= xsas_pkg::QUERY_DEPTH) begin
			pos = 0;
		end
		if (lst) begin
			e.idx = top_idx;
			e.score = top_score;
			expected_best.push_back(e);
			clear_run();
		end
	endtask

	task automatic check_result();
		best_t e;
		seen_count++;
		if (expected_best.size() == 0) begin
			note_mismatch($sformatf("unexpected result: best_index %0d best_score %0d",
				best_index, best_score));
		end else begin
			e = expected_best.pop_front();
			if (best_index !== e.idx)
				note_mismatch($sformatf("result %0d: best_index expected %0d got %0d",
					seen_count, e.idx, best_index));
			if (best_score !== e.score)
				note_mismatch($sformatf("result %0d: best_score expected %0d got %0d",
					seen_count, e.score, best_score));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_reg = xsas_pkg::SIZE_RESET;
			clear_run();
			expected_best.delete();
		end else begin
			// results leave before this edge's input can have produced one
			if (out_valid && out_ready) check_result();
			if (in_valid && in_ready) begin
				if (mode == xsas_pkg::MODE_QUERY) query_copy[query_address] = data_byte;
				else score_byte(data_byte, last);
			end
			if (cfg_valid && cfg_ready) size_reg = cfg_data;
		end
		outstanding <= expected_best.size();
		failures <= fail_count;
		results_seen <= seen_count;
	end

endmodule

>>> dv/xor_score_argmax_search_top_tb.sv
module xor_score_argmax_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int FILL_SPAN   = 256;

	typedef logic [xsas_pkg::ADDR_W-1:0] addr_t;
	typedef logic [xsas_pkg::BYTE_W-1:0] byte_t;
	typedef logic [xsas_pkg::SIZE_W-1:0] size_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [xsas_pkg::SIZE_W-1:0]         cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic                                mode = xsas_pkg::MODE_QUERY;
	logic [xsas_pkg::ADDR_W-1:0]         query_address = '0;
	logic [xsas_pkg::BYTE_W-1:0]         data_byte = '0;
	logic                                last = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [xsas_pkg::INDEX_W-1:0]        best_index;
	logic signed [xsas_pkg::SCORE_W-1:0] best_score;

	int outstanding;
	int failures;
	int results_seen;

	int cycle_count = 0;
	int items_sent = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int cur_size = 1;
	bit hold_off = 1'b0;
	bit press_go = 1'b0;
	logic [xsas_pkg::BYTE_W-1:0] prev_vec [xsas_pkg::QUERY_DEPTH];

	xor_score_argmax_search_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.query_address (query_address),
		.data_byte     (data_byte),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.best_index    (best_index),
		.best_score    (best_score)
	);

	best_match_checker best_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.query_address (query_address),
		.data_byte     (data_byte),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.best_index    (best_index),
		.best_score    (best_score),
		.outstanding   (outstanding),
		.failures      (failures),
		.results_seen  (results_seen)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_count, outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	// long output hold-off so a second last byte backs up into the input
	initial begin
		wait (press_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic send_item(input logic m, input addr_t a, input byte_t d, input logic l);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		query_address <= a;
		data_byte <= d;
		last <= l;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic query_write(input addr_t a, input byte_t d, input logic l);
		send_item(xsas_pkg::MODE_QUERY, a, d, l);
	endtask

	// address is a don't-care for profile bytes, so it carries noise
	task automatic profile_byte(input byte_t d, input logic l);
		send_item(xsas_pkg::MODE_PROFILE,
			addr_t'($urandom_range(xsas_pkg::QUERY_DEPTH - 1)), d, l);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reconfigure(input size_t v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_size = v;
	endtask

	task automatic set_idling(input int s, input int r);
		send_idle = s;
		recv_stall <= r;
	endtask

	// every size stays inside the filled part of the query ram
	function automatic int pick_size();
		int r;
		r = $urandom_range(9);
		if (r < 6) return $urandom_range(1, 8);
		if (r < 9) return $urandom_range(9, 24);
		return $urandom_range(25, 64);
	endfunction

	task automatic long_run(input int n);
		int k;
		for (k = 0; k < n; k++)
			profile_byte(byte_t'($urandom_range(255)), k == n - 1);
	endtask

	// mostly well-formed runs: whole vectors, sometimes a partial tail,
	// with query rewrites sprinkled in
	task automatic random_runs(input int budget);
		int    start;
		int    n_vec;
		int    extra;
		int    total;
		int    k;
		bit    copy_vec;
		byte_t d;
		start = items_sent;
		copy_vec = 1'b0;
		while (items_sent - start < budget) begin
			n_vec = $urandom_range(4);
			extra = ($urandom_range(3) == 0) ? $urandom_range(cur_size - 1) : 0;
			total = n_vec * cur_size + extra;
			if (total == 0) total = 1;
			for (k = 0; k < total; k++) begin
				// a copied vector repeats the previous one's bytes, so it ties unless the query changed
				if (k % cur_size == 0) copy_vec = ($urandom_range(3) == 0);
				if ($urandom_range(99) < 12)
					query_write(addr_t'($urandom_range(xsas_pkg::QUERY_DEPTH - 1)),
						byte_t'($urandom_range(255)), 1'($urandom_range(1)));
				if (copy_vec) begin
					d = prev_vec[k % cur_size];
				end else begin
					case ($urandom_range(5))
						0: d = 8'h00;
						1: d = 8'hFF;
						default: d = byte_t'($urandom_range(255));
					endcase
				end
				prev_vec[k % cur_size] = d;
				profile_byte(d, k == total - 1);
			end
		end
	endtask

	initial begin
		int a;
		int p;
		int phase_send [4];
		int phase_recv [4];
		phase_send = '{0, 69, 0, 32};
		phase_recv = '{0, 0, 69, 32};
		foreach (prev_vec[i]) prev_vec[i] = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// vector size 1 from reset: each byte is a whole vector
		query_write(addr_t'(0), 8'h80, 1'b0);
		query_write(addr_t'(1), 8'h7F, 1'b0);
		query_write(addr_t'(xsas_pkg::QUERY_DEPTH - 1), 8'hA5, 1'b1);
		profile_byte(8'h7F, 1'b1);
		profile_byte(8'h80, 1'b0);
		profile_byte(8'h00, 1'b0);
		profile_byte(8'h7F, 1'b1);
		profile_byte(8'h00, 1'b0);
		profile_byte(8'h00, 1'b1);
		query_write(addr_t'(0), 8'h00, 1'b0);
		profile_byte(8'hFF, 1'b1);

		// last before any vector completes, then a dropped partial tail
		reconfigure(size_t'(2));
		profile_byte(8'h12, 1'b1);
		profile_byte(8'hFF, 1'b0);
		profile_byte(8'h80, 1'b0);
		profile_byte(8'h00, 1'b0);
		profile_byte(8'h00, 1'b0);
		profile_byte(8'hFF, 1'b1);

		// fill the low part of the query ram; every read from here on stays inside it
		settle();
		set_idling(69, 0);
		for (a = 0; a < FILL_SPAN; a++)
			query_write(addr_t'(a), byte_t'($urandom_range(255)), 1'($urandom_range(1)));

		// size zero never completes a vector; an oversized size ends before saturating
		set_idling(0, 69);
		reconfigure(size_t'(0));
		long_run(40);
		set_idling(32, 32);
		reconfigure(11'h7FF);
		long_run(30);

		for (p = 0; p < 4; p++) begin
			settle();
			set_idling(phase_send[p], phase_recv[p]);
			reconfigure(size_t'(pick_size()));
			random_runs(75);
			reconfigure(size_t'(pick_size()));
			random_runs(75);
		end

		reconfigure(size_t'(1));
		set_idling(0, 0);
		press_go <= 1'b1;
		repeat (48) profile_byte(byte_t'($urandom_range(255)), 1'b1);

		settle();
		$display("checked %0d results from %0d input transactions", results_seen, items_sent);
		$display("vector sizes 1, 2, 0, 2047 and random up to 64; four idling mixes; %0d-cycle hold-off",
			HOLD_CYCLES);
		if (failures == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
